// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the diamond map adder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MDMA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MDMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mdma_pkg.sv =====
// Shared widths, codes and controller/datapath types of the diamond map adder.
package mdma_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int FUNC_W     = 2;
    localparam int POS_W      = 6;
    localparam int RADIUS_W   = 8;
    localparam int DELTA_W    = 8;
    localparam int VALUE_W    = 8;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Coordinates inside storage (up to 256 per side) and signed bound arithmetic.
    localparam int COORD_W = 8;
    localparam int CALC_W  = 11;

    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_MARKING = 2'd2;

    localparam logic [DIM_W-1:0] MAP_WIDTH_RST   = 7'd64;
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST  = 7'd64;
    localparam logic             FOG_MARKING_RST = 1'b0;

    typedef logic signed [CALC_W-1:0] calc_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic row_start;
        logic cell_issue;
        logic row_next;
        logic clr_step;
        logic rd_issue;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              rows_done;
        logic              row_empty;
        logic              row_last;
        logic              clr_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/mdma_if.sv =====
// Channel interfaces: command in, response out, configuration write.
interface mdma_cmd_if;
    import mdma_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [POS_W-1:0]           x_pos;
    logic [POS_W-1:0]           y_pos;
    logic signed [RADIUS_W-1:0] radius;
    logic signed [DELTA_W-1:0]  delta;

    modport source (output valid, output func, output x_pos, output y_pos,
                    output radius, output delta, input ready);
    modport sink   (input valid, input func, input x_pos, input y_pos,
                    input radius, input delta, output ready);
endinterface

interface mdma_rsp_if;
    import mdma_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] cell_value;
    logic               fog_mark;

    modport source (output valid, output cell_value, output fog_mark, input ready);
    modport sink   (input valid, input cell_value, input fog_mark, output ready);
endinterface

interface mdma_cfg_if;
    import mdma_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mdma_ctrl.sv =====
// Sequencer of the diamond map adder: clear sweep, row/cell walk, read, result handoff.
`include "assert_macros.svh"

module mdma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mdma_pkg::dp_cmd_t    ctl,
    input  mdma_pkg::dp_status_t stat
);
    import mdma_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_ROW,
        ST_CELL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        case (state_reg)
            ST_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                case (stat.func)
                    FN_ADD:
                    begin
                        ctl.setup  = 1'b1;
                        state_next = ST_ROW;
                    end
                    FN_READ:
                    begin
                        ctl.rd_issue = 1'b1;
                        state_next   = ST_DONE;
                    end
                    FN_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_ROW:
            begin
                if (stat.rows_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.row_start = 1'b1;
                    state_next    = ST_CELL;
                end
            end
            ST_CELL:
            begin
                // Skip a row clipped away entirely, else walk one cell per cycle.
                if (stat.row_empty)
                begin
                    ctl.row_next = 1'b1;
                    state_next   = ST_ROW;
                end
                else
                begin
                    ctl.cell_issue = 1'b1;
                    if (stat.row_last)
                    begin
                        ctl.row_next = 1'b1;
                        state_next   = ST_ROW;
                    end
                end
            end
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free, then hand over the transfer.
                if (out_free)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MDMA_ASSERT_IMPL(a_cell_within_rows, ctl.cell_issue, !stat.rows_done, "cell issued past last row")
    `MDMA_ASSERT_IMPL(a_load_when_free, ctl.load_out, !out_valid_reg || out_ready, "result overwritten")
    `MDMA_ASSERT_NEXT(a_load_shows, ctl.load_out, out_valid_reg, "loaded result not presented")

endmodule

// ===== hw/rtl/mdma_dp.sv =====
// Datapath of the diamond map adder: config, bound math, cell memory, result register.
`include "assert_macros.svh"

module mdma_dp #(
    parameter int MAX_WIDTH  = mdma_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mdma_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mdma_cfg_if.sink                             cfg,
    input  logic [mdma_pkg::FUNC_W-1:0]          func,
    input  logic [mdma_pkg::POS_W-1:0]           x_pos,
    input  logic [mdma_pkg::POS_W-1:0]           y_pos,
    input  logic signed [mdma_pkg::RADIUS_W-1:0] radius,
    input  logic signed [mdma_pkg::DELTA_W-1:0]  delta,
    input  mdma_pkg::dp_cmd_t                    ctl,
    output mdma_pkg::dp_status_t                 stat,
    output logic [mdma_pkg::VALUE_W-1:0]         cell_value,
    output logic                                 fog_mark
);
    import mdma_pkg::*;

    localparam int    DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int    AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int    WORD_W    = VALUE_W + 1;
    localparam int    LIN_W     = 2 * COORD_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam calc_t WIDTH_MAX_C  = calc_t'(MAX_WIDTH);
    localparam calc_t HEIGHT_MAX_C = calc_t'(MAX_HEIGHT);
    localparam calc_t ONE_C        = calc_t'(1);
    localparam calc_t ZERO_C       = calc_t'(0);

    function automatic calc_t calc_max(input calc_t a, input calc_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic calc_t calc_min(input calc_t a, input calc_t b);
        return (a < b) ? a : b;
    endfunction

    // Configuration
    logic [DIM_W-1:0] map_width_reg;
    logic [DIM_W-1:0] map_height_reg;
    logic             fog_marking_reg;

    // Captured item
    logic [FUNC_W-1:0]  func_reg;
    calc_t              cx_reg;
    calc_t              cy_reg;
    calc_t              r_reg;
    logic [VALUE_W-1:0] delta_reg;

    // Walk state
    calc_t y_cur_reg;
    calc_t y_hi_reg;
    calc_t x_cur_reg;
    calc_t x_hi_reg;

    // Memory and write-back
    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  mem_q_reg;
    logic               rd_pend_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [AW-1:0]      clr_addr_reg;

    logic [VALUE_W-1:0] out_value_reg;
    logic               out_mark_reg;

    calc_t w_cfg, h_cfg, w_eff, h_eff;
    calc_t dy_diff, dy, rem;
    logic [LIN_W-1:0]   cell_lin, rd_lin;
    logic [AW-1:0]      cell_addr, rd_addr, wr_addr;
    logic               rd_ok, rd_en, wr_en;
    logic [WORD_W-1:0]  wr_data;
    logic [VALUE_W-1:0] sum_val;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg   <= MAP_WIDTH_RST;
            map_height_reg  <= MAP_HEIGHT_RST;
            fog_marking_reg <= FOG_MARKING_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAP_WIDTH:   map_width_reg   <= cfg.data[DIM_W-1:0];
                CFG_MAP_HEIGHT:  map_height_reg  <= cfg.data[DIM_W-1:0];
                CFG_FOG_MARKING: fog_marking_reg <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // Clip the configured map to storage.
    assign w_cfg = {{(CALC_W-DIM_W){1'b0}}, map_width_reg};
    assign h_cfg = {{(CALC_W-DIM_W){1'b0}}, map_height_reg};
    assign w_eff = calc_min(w_cfg, WIDTH_MAX_C);
    assign h_eff = calc_min(h_cfg, HEIGHT_MAX_C);

    // Half-width of the diamond on the current row.
    assign dy_diff = y_cur_reg - cy_reg;
    assign dy      = (dy_diff < ZERO_C) ? -dy_diff : dy_diff;
    assign rem     = r_reg - dy;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            func_reg  <= func;
            cx_reg    <= {{(CALC_W-POS_W){1'b0}}, x_pos};
            cy_reg    <= {{(CALC_W-POS_W){1'b0}}, y_pos};
            r_reg     <= {{(CALC_W-RADIUS_W){radius[RADIUS_W-1]}}, radius};
            delta_reg <= VALUE_W'(delta);
        end
        // A negative radius leaves the low row bound above the high one.
        if (ctl.setup)
        begin
            y_cur_reg <= calc_max(ZERO_C, cy_reg - r_reg);
            y_hi_reg  <= calc_min(h_eff - ONE_C, cy_reg + r_reg);
        end
        else if (ctl.row_next)
        begin
            y_cur_reg <= y_cur_reg + ONE_C;
        end
        if (ctl.row_start)
        begin
            x_cur_reg <= calc_max(ZERO_C, cx_reg - rem);
            x_hi_reg  <= calc_min(w_eff - ONE_C, cx_reg + rem);
        end
        else if (ctl.cell_issue)
        begin
            x_cur_reg <= x_cur_reg + ONE_C;
        end
        if (ctl.cell_issue)
        begin
            wr_addr_reg <= cell_addr;
        end
        if (ctl.load_out)
        begin
            if (func_reg == FN_READ && rd_ok)
            begin
                out_value_reg <= mem_q_reg[VALUE_W-1:0];
                out_mark_reg  <= mem_q_reg[VALUE_W];
            end
            else
            begin
                out_value_reg <= '0;
                out_mark_reg  <= 1'b0;
            end
        end
    end

    assign cell_lin  = LIN_W'(y_cur_reg[COORD_W-1:0]) * LIN_W'(MAX_WIDTH)
                     + LIN_W'(x_cur_reg[COORD_W-1:0]);
    assign cell_addr = cell_lin[AW-1:0];
    assign rd_lin    = LIN_W'(cy_reg[COORD_W-1:0]) * LIN_W'(MAX_WIDTH)
                     + LIN_W'(cx_reg[COORD_W-1:0]);
    assign rd_ok     = (cx_reg < WIDTH_MAX_C) && (cy_reg < HEIGHT_MAX_C);

    assign rd_en   = ctl.cell_issue || (ctl.rd_issue && rd_ok);
    assign rd_addr = ctl.cell_issue ? cell_addr : rd_lin[AW-1:0];

    // Write back the cell read in the previous cycle, or zero during a clear sweep.
    assign sum_val = mem_q_reg[VALUE_W-1:0] + delta_reg;
    assign wr_en   = rd_pend_reg || ctl.clr_step;
    assign wr_addr = ctl.clr_step ? clr_addr_reg : wr_addr_reg;
    assign wr_data = ctl.clr_step ? '0 : {mem_q_reg[VALUE_W] | fog_marking_reg, sum_val};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg  <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            rd_pend_reg <= ctl.cell_issue;
            if (ctl.clr_step)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + AW'(1);
            end
        end
    end

    assign stat.func      = func_reg;
    assign stat.rows_done = (y_cur_reg > y_hi_reg);
    assign stat.row_empty = (x_cur_reg > x_hi_reg);
    assign stat.row_last  = (x_cur_reg == x_hi_reg);
    assign stat.clr_last  = (clr_addr_reg == LAST_ADDR);

    assign cell_value = out_value_reg;
    assign fog_mark   = out_mark_reg;

    `MDMA_ASSERT_IMPL(a_rmw_distinct, rd_pend_reg && ctl.cell_issue,
                      wr_addr_reg != cell_addr, "read-modify-write overlap")
    `MDMA_ASSERT_IMPL(a_clear_no_pend, ctl.clr_step, !rd_pend_reg,
                      "clear collides with write-back")
    `MDMA_ASSERT_IMPL(a_cell_in_store, ctl.cell_issue,
                      (x_cur_reg < WIDTH_MAX_C) && (y_cur_reg < HEIGHT_MAX_C),
                      "cell outside storage")

endmodule

// ===== hw/rtl/manhattan_diamond_map_add.sv =====
// Usage: the diamond map adder keeps a counter grid and a mark grid.
// Channels: cmd takes func, x_pos, y_pos, radius, delta; rsp returns cell_value
// and fog_mark, one transfer per command; cfg writes map_width (index 0),
// map_height (index 1) and fog_marking (index 2); cfg is always ready, and the
// user must write it only while idle: the block itself does not enforce this.
// Commands run one at a time through a single memory with one read and one
// write port. From command transfer to response valid: add sets up the row
// bounds, then for each touched row computes its column bounds and walks its
// cells, one read-modify-write per cell, pipelined at one cell per cycle; read
// fetches one cell; clear zeroes one entry per cycle over the whole store;
// other functions go straight to the response.
// The next command is taken the cycle after the previous response is loaded.
// Reset: configuration returns to 64 x 64 with marking off, then a clearing
// pass of MAX_WIDTH*MAX_HEIGHT writes (4096 at default size) zeroes the grids
// with cmd.ready low. A stalled rsp holds its result; the next command is
// still taken and runs, waiting at its end until the response register frees.
module manhattan_diamond_map_add #(
    parameter int MAX_WIDTH  = mdma_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mdma_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mdma_cfg_if.sink    cfg,
    mdma_cmd_if.sink    cmd,
    mdma_rsp_if.source  rsp
);
    import mdma_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t stat;

    mdma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    mdma_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .func       (cmd.func),
        .x_pos      (cmd.x_pos),
        .y_pos      (cmd.y_pos),
        .radius     (cmd.radius),
        .delta      (cmd.delta),
        .ctl        (ctl),
        .stat       (stat),
        .cell_value (rsp.cell_value),
        .fog_mark   (rsp.fog_mark)
    );

endmodule
